// File: design/qrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// qrs_pkg
// Shared types and constants of the quadratic real-root solver.
// ============================================================================
package qrs_pkg;

    localparam int COEF_WIDTH_DEF     = 16;
    localparam int ROOT_FRAC_BITS_DEF = 16;
    localparam int COEF_FRAC          = 8;
    localparam int ROOT_OUT_WIDTH     = 40;

    typedef enum logic [1:0] {
        ST_TWO    = 2'd0,
        ST_DOUBLE = 2'd1,
        ST_NONE   = 2'd2,
        ST_A_ZERO = 2'd3
    } root_status_t;

    // Per-item control that rides alongside the numeric pipelines.
    typedef struct packed {
        root_status_t status;
        logic         neg_one;
        logic         neg_two;
    } root_ctrl_t;

endpackage
`default_nettype wire

// File: design/qrs_disc.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// qrs_disc
// Two-stage discriminant unit: products, then b*b - 4ac, status and the
// scaled square-root operand.
// ============================================================================
module qrs_disc
    import qrs_pkg::*;
#(
    parameter int CW = COEF_WIDTH_DEF,
    parameter int SH = 16,
    parameter int SW = 50
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic signed [CW-1:0] a,
    input  wire logic signed [CW-1:0] b,
    input  wire logic signed [CW-1:0] c,
    output logic                      out_valid,
    output root_status_t              status,
    output logic signed [CW-1:0]      a_out,
    output logic signed [CW-1:0]      b_out,
    output logic [SW-1:0]             operand
);
    localparam int DW = 2 * CW + 3;

    logic                   v1_reg, v2_reg;
    logic signed [2*CW-1:0] bb_reg, ac_reg;
    logic signed [CW-1:0]   a1_reg, b1_reg, a2_reg, b2_reg;
    root_status_t           st_reg, st_next;
    logic [SW-1:0]          op_reg, op_next;
    logic signed [DW-1:0]   disc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bb_reg <= b * b;
        ac_reg <= a * c;
        a1_reg <= a;
        b1_reg <= b;
        a2_reg <= a1_reg;
        b2_reg <= b1_reg;
        st_reg <= st_next;
        op_reg <= op_next;
    end

    always_comb
    begin
        disc = DW'(bb_reg) - (DW'(ac_reg) <<< 2);
        if (a1_reg == '0)
            st_next = ST_A_ZERO;
        else if (disc[DW-1])
            st_next = ST_NONE;
        else if (disc == '0)
            st_next = ST_DOUBLE;
        else
            st_next = ST_TWO;
        op_next = disc[DW-1] ? '0 : (SW'(disc[DW-2:0]) << SH);
    end

    assign out_valid = v2_reg;
    assign status    = st_reg;
    assign a_out     = a2_reg;
    assign b_out     = b2_reg;
    assign operand   = op_reg;

endmodule
`default_nettype wire

// File: design/qrs_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// qrs_sqrt
// Pipelined floor square root, one result bit per register stage, with a
// side vector carried along.
// ============================================================================
module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int SW    = 50,
    parameter int SIDEW = 34
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [SW-1:0]    operand,
    input  wire logic [SIDEW-1:0] side_in,
    output logic                  out_valid,
    output logic [SW/2-1:0]       root,
    output logic [SIDEW-1:0]      side_out
);
    localparam int HW = SW / 2;
    localparam int RW = HW + 2;

    logic [HW:1]      v_reg;
    logic [SW-1:0]    op_reg   [1:HW];
    logic [RW-1:0]    rem_reg  [1:HW];
    logic [HW-1:0]    root_reg [1:HW];
    logic [SIDEW-1:0] side_reg [1:HW];

    for (genvar k = 0; k < HW; k++)
    begin : g_stage
        logic             v_cur;
        logic [SW-1:0]    op_cur;
        logic [RW-1:0]    rem_cur;
        logic [HW-1:0]    root_cur;
        logic [SIDEW-1:0] side_cur;
        logic [RW-1:0]    rem_sh, trial;
        logic             ge;

        // The first stage takes the beat straight from the inputs.
        if (k == 0)
        begin : g_first
            assign v_cur    = in_valid;
            assign op_cur   = operand;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign side_cur = side_in;
        end
        else
        begin : g_rest
            assign v_cur    = v_reg[k];
            assign op_cur   = op_reg[k];
            assign rem_cur  = rem_reg[k];
            assign root_cur = root_reg[k];
            assign side_cur = side_reg[k];
        end

        always_comb
        begin
            rem_sh = {rem_cur[RW-3:0], op_cur[SW-1 -: 2]};
            trial  = {root_cur, 2'b01};
            ge     = rem_sh >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else
                v_reg[k+1] <= v_cur;
        end

        always_ff @(posedge clk)
        begin
            op_reg[k+1]   <= op_cur << 2;
            rem_reg[k+1]  <= ge ? rem_sh - trial : rem_sh;
            root_reg[k+1] <= {root_cur[HW-2:0], ge};
            side_reg[k+1] <= side_cur;
        end
    end

    assign out_valid = v_reg[HW];
    assign root      = root_reg[HW];
    assign side_out  = side_reg[HW];

endmodule
`default_nettype wire

// File: design/qrs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// qrs_div
// Pipelined unsigned restoring divider, one quotient bit per register
// stage, with a side vector carried along.
// ============================================================================
module qrs_div
    import qrs_pkg::*;
#(
    parameter int NW    = 34,
    parameter int DV    = 16,
    parameter int SIDEW = 4
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [NW-1:0]    dividend,
    input  wire logic [DV-1:0]    divisor,
    input  wire logic [SIDEW-1:0] side_in,
    output logic                  out_valid,
    output logic [NW-1:0]         quotient,
    output logic [SIDEW-1:0]      side_out
);
    logic [NW:1]      v_reg;
    logic [NW-1:0]    n_reg    [1:NW];
    logic [DV-1:0]    d_reg    [1:NW];
    logic [DV:0]      rem_reg  [1:NW];
    logic [NW-1:0]    q_reg    [1:NW];
    logic [SIDEW-1:0] side_reg [1:NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic             v_cur;
        logic [NW-1:0]    n_cur;
        logic [DV-1:0]    d_cur;
        logic [DV:0]      rem_cur;
        logic [NW-1:0]    q_cur;
        logic [SIDEW-1:0] side_cur;
        logic [DV:0]      rem_sh;
        logic             ge;

        // The first stage takes the beat straight from the inputs.
        if (k == 0)
        begin : g_first
            assign v_cur    = in_valid;
            assign n_cur    = dividend;
            assign d_cur    = divisor;
            assign rem_cur  = '0;
            assign q_cur    = '0;
            assign side_cur = side_in;
        end
        else
        begin : g_rest
            assign v_cur    = v_reg[k];
            assign n_cur    = n_reg[k];
            assign d_cur    = d_reg[k];
            assign rem_cur  = rem_reg[k];
            assign q_cur    = q_reg[k];
            assign side_cur = side_reg[k];
        end

        always_comb
        begin
            rem_sh = {rem_cur[DV-1:0], n_cur[NW-1]};
            ge     = rem_sh >= {1'b0, d_cur};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else
                v_reg[k+1] <= v_cur;
        end

        always_ff @(posedge clk)
        begin
            n_reg[k+1]    <= n_cur << 1;
            d_reg[k+1]    <= d_cur;
            rem_reg[k+1]  <= ge ? rem_sh - {1'b0, d_cur} : rem_sh;
            q_reg[k+1]    <= {q_cur[NW-2:0], ge};
            side_reg[k+1] <= side_cur;
        end
    end

    assign out_valid = v_reg[NW];
    assign quotient  = q_reg[NW];
    assign side_out  = side_reg[NW];

endmodule
`default_nettype wire

// File: design/quadratic_real_root_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// quadratic_real_root_solver
// Real roots of a*x^2 + b*x + c = 0 from signed Q8.8 coefficients.
// ============================================================================
// Usage:
//   A coefficient beat is taken at a clock edge where start is high and busy
//   is low. busy never rises, so one beat can enter every cycle.
//   Each result beat appears on root_status, smaller_root and larger_root
//   for exactly one cycle with done high; it must be captured then.
//   A beat passes the discriminant stages, S square-root stages (half the
//   scaled operand width, 25 at defaults), the numerator register, Q divider
//   stages (dividend width, 34 at defaults) and the output register.
//   Throughput is one beat per cycle, set by the fully pipelined square root
//   and the two pipelined restoring dividers, one bit per stage each.
//   Reset clears all valid bits; items in flight are dropped.
//   Status 3 flags a zero a and status 2 no real roots; both give zero roots.
// ============================================================================
module quadratic_real_root_solver
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH     = COEF_WIDTH_DEF,
    parameter int ROOT_FRAC_BITS = ROOT_FRAC_BITS_DEF
)(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COEF_WIDTH-1:0] coef_a,
    input  wire logic signed [COEF_WIDTH-1:0] coef_b,
    input  wire logic signed [COEF_WIDTH-1:0] coef_c,
    output logic                              done,
    output logic [1:0]                        root_status,
    output logic signed [ROOT_OUT_WIDTH-1:0]  smaller_root,
    output logic signed [ROOT_OUT_WIDTH-1:0]  larger_root
);
    localparam int CW    = COEF_WIDTH;
    localparam int DW    = 2 * CW + 3;
    localparam int SH    = 2 * ROOT_FRAC_BITS - 2 * COEF_FRAC;
    localparam int SWR   = DW - 1 + SH;
    localparam int SW    = SWR + (SWR % 2);
    localparam int HW    = SW / 2;
    localparam int NBW   = CW + ROOT_FRAC_BITS - COEF_FRAC + 1;
    localparam int NW    = ((HW + 1 > NBW) ? HW + 1 : NBW) + 1;
    localparam int QW    = NW + COEF_FRAC - 1;
    localparam int CTRLW = $bits(root_ctrl_t);
    localparam int OW    = ROOT_OUT_WIDTH;
    localparam int LAT   = 2 + HW + 1 + QW + 1;

    wire start_ok = start && !busy;

    // Discriminant stages.
    logic                 d_valid;
    root_status_t         d_status;
    logic signed [CW-1:0] d_a, d_b;
    logic [SW-1:0]        d_operand;

    qrs_disc #(.CW(CW), .SH(SH), .SW(SW)) u_disc (
        .clk(clk), .rst_n(rst_n), .in_valid(start_ok),
        .a(coef_a), .b(coef_b), .c(coef_c),
        .out_valid(d_valid), .status(d_status), .a_out(d_a), .b_out(d_b),
        .operand(d_operand)
    );

    // Square root.
    logic                 s_valid;
    logic [HW-1:0]        s_root;
    logic [2*CW+1:0]      s_side;
    root_status_t         s_status;
    logic signed [CW-1:0] s_a, s_b;

    qrs_sqrt #(.SW(SW), .SIDEW(2 * CW + 2)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .in_valid(d_valid), .operand(d_operand),
        .side_in({d_status, d_a, d_b}),
        .out_valid(s_valid), .root(s_root), .side_out(s_side)
    );

    always_comb
    begin
        s_status = root_status_t'(s_side[2*CW+1 -: 2]);
        s_a      = $signed(s_side[2*CW-1 -: CW]);
        s_b      = $signed(s_side[CW-1:0]);
    end

    // Numerator stage: -b scaled, plus and minus the root, split into sign
    // and magnitude for the unsigned dividers.
    logic                 n_valid_reg;
    logic [NW-1:0]        mag1_reg, mag2_reg;
    logic [CW-1:0]        amag_reg;
    root_ctrl_t           ctrl_reg, ctrl_next;
    logic signed [NW-1:0] nb, sx, num1, num2;
    logic [NW-1:0]        mag1_next, mag2_next;
    logic [CW-1:0]        amag_next;

    always_comb
    begin
        nb        = -(NW'(s_b) <<< (ROOT_FRAC_BITS - COEF_FRAC));
        sx        = $signed(NW'(s_root));
        num1      = nb + sx;
        num2      = nb - sx;
        mag1_next = num1[NW-1] ? NW'(-num1) : NW'(num1);
        mag2_next = num2[NW-1] ? NW'(-num2) : NW'(num2);
        amag_next = s_a[CW-1] ? CW'(-s_a) : CW'(s_a);
        ctrl_next.status  = s_status;
        ctrl_next.neg_one = num1[NW-1] ^ s_a[CW-1];
        ctrl_next.neg_two = num2[NW-1] ^ s_a[CW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_valid_reg <= 1'b0;
        else
            n_valid_reg <= s_valid;
    end

    always_ff @(posedge clk)
    begin
        mag1_reg <= mag1_next;
        mag2_reg <= mag2_next;
        amag_reg <= amag_next;
        ctrl_reg <= ctrl_next;
    end

    // Dividers.
    logic             q_valid, q2_valid;
    logic [QW-1:0]    q1, q2;
    logic [CTRLW-1:0] q_side;
    logic [0:0]       q2_side;
    root_ctrl_t       q_ctrl;

    qrs_div #(.NW(QW), .DV(CW), .SIDEW(CTRLW)) u_div_one (
        .clk(clk), .rst_n(rst_n), .in_valid(n_valid_reg),
        .dividend({mag1_reg, {(COEF_FRAC - 1){1'b0}}}), .divisor(amag_reg),
        .side_in(ctrl_reg),
        .out_valid(q_valid), .quotient(q1), .side_out(q_side)
    );

    // The second divider carries the sign of its own quotient.
    qrs_div #(.NW(QW), .DV(CW), .SIDEW(1)) u_div_two (
        .clk(clk), .rst_n(rst_n), .in_valid(n_valid_reg),
        .dividend({mag2_reg, {(COEF_FRAC - 1){1'b0}}}), .divisor(amag_reg),
        .side_in(ctrl_reg.neg_two),
        .out_valid(q2_valid), .quotient(q2), .side_out(q2_side)
    );

    // Sign, ordering and output register.
    logic signed [OW-1:0] r1, r2, lo_next, hi_next;
    logic signed [OW-1:0] lo_reg, hi_reg;
    logic [1:0]           st_reg;
    logic                 done_reg;
    logic                 no_roots;

    always_comb
    begin
        q_ctrl   = root_ctrl_t'(q_side);
        r1       = q_ctrl.neg_one ? -$signed(OW'(q1)) : $signed(OW'(q1));
        r2       = q2_side[0] ? -$signed(OW'(q2)) : $signed(OW'(q2));
        no_roots = (q_ctrl.status == ST_NONE) || (q_ctrl.status == ST_A_ZERO);
        if (no_roots)
        begin
            lo_next = '0;
            hi_next = '0;
        end
        else if (r1 < r2)
        begin
            lo_next = r1;
            hi_next = r2;
        end
        else
        begin
            lo_next = r2;
            hi_next = r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        st_reg <= q_ctrl.status;
    end

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign root_status  = st_reg;
    assign smaller_root = lo_reg;
    assign larger_root  = hi_reg;

    // Both dividers must stay in lockstep.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid == q2_valid)
        else $error("divider valid bits out of step");

    // A result beat leaves the full pipeline depth LAT after its input beat.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start_ok, LAT))
        else $error("result beat without matching input beat");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (smaller_root <= larger_root))
        else $error("roots out of order");

    a_double: assert property (@(posedge clk) disable iff (!rst_n)
        (done && root_status == ST_DOUBLE) |-> (smaller_root == larger_root))
        else $error("double root with unequal fields");

endmodule
`default_nettype wire
